### hw/rtl/pcl_pkg.sv
// Package for the positional character list: command, status and chain codes,
// and the control word that the core sends to every cell of the chain.
// Has no dependencies.
package pcl_pkg;

  // Fixed field widths.
  localparam int unsigned CmdW = 2;
  localparam int unsigned PosW = 7;
  localparam int unsigned SymW = 8;
  localparam int unsigned StW  = 2;

  // Default number of cells.
  localparam int unsigned CapacityDefault = 64;

  // Command codes.
  localparam logic [CmdW-1:0] CmdAdd   = 2'd0;
  localparam logic [CmdW-1:0] CmdDel   = 2'd1;
  localparam logic [CmdW-1:0] CmdGet   = 2'd2;
  localparam logic [CmdW-1:0] CmdPrint = 2'd3;

  // Status codes.
  localparam logic [StW-1:0] StOk      = 2'd0;
  localparam logic [StW-1:0] StInvalid = 2'd1;
  localparam logic [StW-1:0] StFull    = 2'd2;
  localparam logic [StW-1:0] StEmpty   = 2'd3;

  // Chain operation codes.
  localparam logic [1:0] OpHold = 2'd0;
  localparam logic [1:0] OpIns  = 2'd1;
  localparam logic [1:0] OpDel  = 2'd2;
  localparam logic [1:0] OpRot  = 2'd3;

  // Control word broadcast along the chain.
  typedef struct packed {
    logic [1:0]      op;
    logic [PosW-1:0] slot;      // zero-based target cell for insert and delete
    logic [PosW-1:0] tail;      // zero-based index of the last element in use
    logic [SymW-1:0] sym;       // byte written on insert
  } chain_ctrl_t;

endpackage

### hw/rtl/pcl_cell.sv
// One storage cell of the character chain.
// Depends on pcl_pkg for the control word and the operation codes.
module pcl_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                      clk_i,
  input  pcl_pkg::chain_ctrl_t      ctrl_i,
  input  logic [pcl_pkg::SymW-1:0]  left_i,
  input  logic [pcl_pkg::SymW-1:0]  right_i,
  input  logic [pcl_pkg::SymW-1:0]  head_i,
  output logic [pcl_pkg::SymW-1:0]  data_o
);

  localparam logic [pcl_pkg::PosW-1:0] IdxP = pcl_pkg::PosW'(Idx);

  logic [pcl_pkg::SymW-1:0] data_d, data_q;

  // Pick the next byte from this cell, a neighbor, the head or the new byte.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      pcl_pkg::OpIns: begin
        if (IdxP > ctrl_i.slot) begin
          data_d = left_i;
        end else if (IdxP == ctrl_i.slot) begin
          data_d = ctrl_i.sym;
        end
      end
      pcl_pkg::OpDel: begin
        if (IdxP >= ctrl_i.slot) begin
          data_d = right_i;
        end
      end
      pcl_pkg::OpRot: begin
        if (IdxP == ctrl_i.tail) begin
          data_d = head_i;
        end else if (IdxP < ctrl_i.tail) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  // Payload storage, written before it is ever read.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hw/rtl/positional_char_list_core.sv
// Top level of the positional character list: command decode, output register
// and the chain of pcl_cell instances. Depends on pcl_pkg and pcl_cell.
//
// Add, delete and get are accepted and their single result word appears in the
// output register on the next cycle; a new command can be taken every cycle
// while the output side takes words. Print of a list of N elements gives N
// words: the chain rotates one cell per cycle through its first N cells and
// emits the head each cycle while the output side takes words, which leaves
// the list in its original order at the end. An empty print gives one word.
// The single output register sets the pace: the input stalls while a word
// waits there under stall and while a print is running.
module positional_char_list_core #(
  parameter int unsigned CAPACITY = pcl_pkg::CapacityDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [pcl_pkg::CmdW-1:0]  command_i,
  input  logic [pcl_pkg::PosW-1:0]  position_i,
  input  logic [pcl_pkg::SymW-1:0]  symbol_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pcl_pkg::SymW-1:0]  symbol_out_o,
  output logic [pcl_pkg::StW-1:0]   status_o,
  output logic                      last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned PosW = pcl_pkg::PosW;

  logic [CntW-1:0] count_d, count_q;
  logic [CntW-1:0] pidx_d, pidx_q;
  logic            printing_d, printing_q;
  logic            ovalid_d, ovalid_q;
  logic [pcl_pkg::SymW-1:0] osym_d, osym_q;
  logic [pcl_pkg::StW-1:0]  ost_d, ost_q;
  logic            olast_d, olast_q;

  logic [pcl_pkg::SymW-1:0] cell_data [CAPACITY];
  pcl_pkg::chain_ctrl_t     ctrl;

  logic            slot_free;
  logic            accept;
  logic [PosW:0]   pos_x;
  logic [PosW:0]   cnt_x;
  logic            pos_zero;
  logic            add_ok;
  logic            idx_ok;
  logic            full;
  logic [PosW-1:0] pos_m1;
  logic            print_last;

  // Handshake.
  assign slot_free  = !ovalid_q || !out_stall_i;
  assign in_stall_o = printing_q || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;

  // Position checks.
  assign pos_x      = {1'b0, position_i};
  assign cnt_x      = (PosW + 1)'(count_q);
  assign pos_zero   = (position_i == '0);
  assign add_ok     = !pos_zero && (pos_x <= cnt_x + 1'b1);
  assign idx_ok     = !pos_zero && (pos_x <= cnt_x);
  assign full       = (count_q == CntW'(CAPACITY));
  assign pos_m1     = position_i - 1'b1;
  assign print_last = (pidx_q == count_q - 1'b1);

  // Decode, chain control and output word.
  always_comb begin
    count_d    = count_q;
    pidx_d     = pidx_q;
    printing_d = printing_q;
    ovalid_d   = ovalid_q && out_stall_i;
    osym_d     = osym_q;
    ost_d      = ost_q;
    olast_d    = olast_q;
    ctrl.op    = pcl_pkg::OpHold;
    ctrl.slot  = pos_m1;
    ctrl.tail  = PosW'(count_q) - 1'b1;
    ctrl.sym   = symbol_in_i;
    if (accept) begin
      ovalid_d = 1'b1;
      osym_d   = '0;
      olast_d  = 1'b1;
      case (command_i)
        pcl_pkg::CmdAdd: begin
          if (!add_ok) begin
            ost_d = pcl_pkg::StInvalid;
          end else if (full) begin
            ost_d = pcl_pkg::StFull;
          end else begin
            ost_d   = pcl_pkg::StOk;
            ctrl.op = pcl_pkg::OpIns;
            count_d = count_q + 1'b1;
          end
        end
        pcl_pkg::CmdDel: begin
          if (!idx_ok) begin
            ost_d = pcl_pkg::StInvalid;
          end else begin
            ost_d   = pcl_pkg::StOk;
            ctrl.op = pcl_pkg::OpDel;
            count_d = count_q - 1'b1;
          end
        end
        pcl_pkg::CmdGet: begin
          if (!idx_ok) begin
            ost_d = pcl_pkg::StInvalid;
          end else begin
            ost_d  = pcl_pkg::StOk;
            osym_d = cell_data[pos_m1[IdxW-1:0]];
          end
        end
        default: begin
          if (count_q == '0) begin
            ost_d = pcl_pkg::StEmpty;
          end else begin
            // Words come out of the rotation once printing is registered.
            ovalid_d   = 1'b0;
            printing_d = 1'b1;
            pidx_d     = '0;
          end
        end
      endcase
    end else if (printing_q && slot_free) begin
      ovalid_d = 1'b1;
      osym_d   = cell_data[0];
      ost_d    = pcl_pkg::StOk;
      olast_d  = print_last;
      ctrl.op  = pcl_pkg::OpRot;
      pidx_d   = pidx_q + 1'b1;
      if (print_last) begin
        printing_d = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pidx_q     <= '0;
      printing_q <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      count_q    <= count_d;
      pidx_q     <= pidx_d;
      printing_q <= printing_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    osym_q  <= osym_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
  end

  assign out_valid_o  = ovalid_q;
  assign symbol_out_o = osym_q;
  assign status_o     = ost_q;
  assign last_o       = olast_q;

  // The chain of cells; the ends see their own byte where no neighbor exists.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [pcl_pkg::SymW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cell_data[0];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pcl_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(right),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

endmodule

### hw/rtl/pcl_checker.sv
// Port-level checks for positional_char_list_core, attached by a bind.
// Depends on pcl_pkg for command and status codes.
module pcl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [pcl_pkg::CmdW-1:0]  command_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [pcl_pkg::SymW-1:0]  symbol_out_o,
  input logic [pcl_pkg::StW-1:0]   status_o,
  input logic                      last_o
);

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_out_o)
      && $stable(status_o) && $stable(last_o))
    else $error("stalled output word changed");

  // Any error word ends its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pcl_pkg::StOk) |-> last_o)
    else $error("error word without last");

  // Error words carry no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pcl_pkg::StOk) |-> (symbol_out_o == '0))
    else $error("error word with nonzero byte");

  // An add, delete or get answers on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (command_i != pcl_pkg::CmdPrint)
      |=> out_valid_o && last_o)
    else $error("missing answer word");

endmodule

bind positional_char_list_core pcl_checker u_pcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .symbol_out_o(symbol_out_o),
  .status_o    (status_o),
  .last_o      (last_o)
);
